FILE: src/sfb_pkg.sv
// sfb_pkg: shared types, constants and the crc byte fold for the slip frame builder
// no dependencies; imported by every module of the block
`default_nettype none

package sfb_pkg;

    // operation codes carried on the slave tuser
    localparam logic [1:0] OP_START = 2'd0;
    localparam logic [1:0] OP_DATA  = 2'd1;
    localparam logic [1:0] OP_END   = 2'd2;

    // crc-16 reflected, poly 0x8408
    localparam logic [15:0] CRC_POLY = 16'h8408;
    localparam logic [15:0] CRC_SEED = 16'hFFFF;

    // slip special bytes
    localparam logic [7:0] SLIP_END  = 8'hC0;
    localparam logic [7:0] SLIP_ESC  = 8'hDB;
    localparam logic [7:0] SLIP_TEND = 8'hDC;
    localparam logic [7:0] SLIP_TESC = 8'hDD;

    // most bytes one job expands to (end: two escaped crc bytes plus frame end)
    localparam int unsigned RUN_MAX = 5;
    localparam int unsigned RUN_W   = 3;

    // job kinds handed from front to back
    typedef enum logic [1:0] {
        JOB_START,
        JOB_DATA,
        JOB_END
    } job_kind_t;

    // one queued job
    typedef struct packed {
        job_kind_t  kind;
        logic [7:0] b0;    // source, payload byte or crc low
        logic [7:0] b1;    // control or crc high
        logic [7:0] dest;  // destination of the frame in progress
    } job_t;

    // fold one byte into the reflected crc, lsb first
    function automatic logic [15:0] crc_fold(input logic [15:0] crc_in, input logic [7:0] b);
        logic [15:0] c;
        logic        fb;
        c = crc_in;
        for (int i = 0; i < 8; i++)
        begin
            fb = b[i] ^ c[0];
            c  = {1'b0, c[15:1]};
            if (fb)
            begin
                c = c ^ CRC_POLY;
            end
        end
        return c;
    endfunction

endpackage

`default_nettype wire

FILE: src/sfb_front.sv
// sfb_front: accepts input beats, keeps frame state and crc, pushes jobs to the queue
// depends on sfb_pkg
`default_nettype none

module sfb_front (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          s_tvalid,
    output logic               s_tready,
    input  wire logic [31:0]   s_tdata,   // dest_address, source_address, control_field, payload_byte
    input  wire logic [1:0]    s_tuser,   // operation
    input  wire logic          q_full,
    output logic               q_push,
    output sfb_pkg::job_t      q_job
);
    import sfb_pkg::*;

    localparam logic [1:0] HDR_NONE = 2'd0;
    localparam logic [1:0] HDR_ONE  = 2'd1;
    localparam logic [1:0] HDR_TWO  = 2'd2;

    logic [15:0] crc_reg, crc_next;
    logic [7:0]  held_dest_reg, held_dest_next;
    logic        in_frame_reg, in_frame_next;
    logic [1:0]  hdr_cnt_reg, hdr_cnt_next;
    logic [7:0]  src_pend_reg, src_pend_next;
    logic [7:0]  ctl_pend_reg, ctl_pend_next;

    logic [7:0]  dst, src, ctl, pay;
    logic        accept;

    assign dst = s_tdata[7:0];
    assign src = s_tdata[15:8];
    assign ctl = s_tdata[23:16];
    assign pay = s_tdata[31:24];

    // hold off while header bytes are still being folded or the queue is full
    assign s_tready = (hdr_cnt_reg == HDR_NONE) && !q_full;
    assign accept   = s_tvalid && s_tready;

    // classify the beat and update frame state
    always_comb
    begin
        crc_next       = crc_reg;
        held_dest_next = held_dest_reg;
        in_frame_next  = in_frame_reg;
        hdr_cnt_next   = hdr_cnt_reg;
        src_pend_next  = src_pend_reg;
        ctl_pend_next  = ctl_pend_reg;
        q_push         = 1'b0;
        q_job.kind     = JOB_DATA;
        q_job.b0       = pay;
        q_job.b1       = ctl;
        q_job.dest     = held_dest_reg;

        // finish header crc one byte per cycle
        if (hdr_cnt_reg != HDR_NONE)
        begin
            crc_next     = crc_fold(crc_reg, (hdr_cnt_reg == HDR_TWO) ? src_pend_reg
                                                                      : ctl_pend_reg);
            hdr_cnt_next = hdr_cnt_reg - HDR_ONE;
        end

        if (accept)
        begin
            case (s_tuser)
                OP_START:
                begin
                    held_dest_next = dst;
                    in_frame_next  = 1'b1;
                    crc_next       = crc_fold(CRC_SEED, dst);
                    src_pend_next  = src;
                    ctl_pend_next  = ctl;
                    hdr_cnt_next   = HDR_TWO;
                    q_push         = 1'b1;
                    q_job.kind     = JOB_START;
                    q_job.b0       = src;
                    q_job.b1       = ctl;
                    q_job.dest     = dst;
                end
                OP_DATA:
                begin
                    if (in_frame_reg)
                    begin
                        crc_next = crc_fold(crc_reg, pay);
                        q_push   = 1'b1;
                    end
                end
                OP_END:
                begin
                    if (in_frame_reg)
                    begin
                        in_frame_next = 1'b0;
                        q_push        = 1'b1;
                        q_job.kind    = JOB_END;
                        q_job.b0      = crc_reg[7:0];
                        q_job.b1      = crc_reg[15:8];
                    end
                end
                default:
                begin
                    q_push = 1'b0;
                end
            endcase
        end
    end

    // control and crc state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            crc_reg       <= CRC_SEED;
            held_dest_reg <= 8'h00;
            in_frame_reg  <= 1'b0;
            hdr_cnt_reg   <= HDR_NONE;
        end
        else
        begin
            crc_reg       <= crc_next;
            held_dest_reg <= held_dest_next;
            in_frame_reg  <= in_frame_next;
            hdr_cnt_reg   <= hdr_cnt_next;
        end
    end

    // pending header bytes
    always_ff @(posedge clk)
    begin
        src_pend_reg <= src_pend_next;
        ctl_pend_reg <= ctl_pend_next;
    end

endmodule

`default_nettype wire

FILE: src/sfb_queue.sv
// sfb_queue: small job queue between front and back
// depends on sfb_pkg
`default_nettype none

module sfb_queue #(
    parameter int unsigned DEPTH = 4
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          push,
    input  wire sfb_pkg::job_t push_job,
    output logic               full,
    input  wire logic          pop,
    output sfb_pkg::job_t      pop_job,
    output logic               empty
);
    import sfb_pkg::*;

    localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W  = $clog2(DEPTH + 1);
    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(DEPTH - 1);

    job_t              mem [DEPTH];
    logic [ADDR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [ADDR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign pop_job = mem[rd_ptr_reg];

    // pointer and count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_ADDR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_ADDR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // job storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_job;
        end
    end

endmodule

`default_nettype wire

FILE: src/sfb_back.sv
// sfb_back: expands queued jobs into slip-escaped frame bytes,
// one beat per cycle while m_tready is high; depends on sfb_pkg
`default_nettype none

module sfb_back (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          q_empty,
    input  wire sfb_pkg::job_t q_job,
    output logic               q_pop,
    output logic               m_tvalid,
    input  wire logic          m_tready,
    output logic [15:0]        m_tdata,   // frame_byte, frame_dest
    output logic [0:0]         m_tuser,   // run_last
    output logic               m_tlast    // frame_last
);
    import sfb_pkg::*;

    localparam logic [RUN_W-1:0] RUN_ONE = RUN_W'(1);

    // current run of bytes
    logic [7:0]       run_bytes_reg [RUN_MAX];
    logic [7:0]       run_bytes_next [RUN_MAX];
    logic [RUN_W-1:0] run_cnt_reg, run_cnt_next;
    logic [RUN_W-1:0] run_idx_reg, run_idx_next;
    logic             run_end_reg, run_end_next;
    logic [7:0]       run_dest_reg, run_dest_next;
    logic             run_active_reg, run_active_next;

    // output register
    logic             out_valid_reg, out_valid_next;
    logic [7:0]       out_byte_reg, out_byte_next;
    logic [7:0]       out_dest_reg, out_dest_next;
    logic             out_run_last_reg, out_run_last_next;
    logic             out_frame_last_reg, out_frame_last_next;

    logic             emit, last;
    logic [7:0]       exp_bytes [RUN_MAX];
    logic [RUN_W-1:0] exp_cnt;

    assign m_tvalid   = out_valid_reg;
    assign m_tdata    = {out_dest_reg, out_byte_reg};
    assign m_tuser[0] = out_run_last_reg;
    assign m_tlast    = out_frame_last_reg;

    assign emit  = run_active_reg && (!out_valid_reg || m_tready);
    assign last  = (run_idx_reg == run_cnt_reg - RUN_ONE);
    assign q_pop = !q_empty && (!run_active_reg || (emit && last));

    // expand the job at the queue head into its byte run
    always_comb
    begin
        for (int i = 0; i < RUN_MAX; i++)
        begin
            exp_bytes[i] = SLIP_END;
        end
        exp_cnt = '0;
        case (q_job.kind)
            JOB_START:
            begin
                exp_bytes[0] = q_job.b0;
                exp_bytes[1] = q_job.b1;
                exp_cnt      = RUN_W'(2);
            end
            JOB_DATA:
            begin
                if (q_job.b0 == SLIP_END || q_job.b0 == SLIP_ESC)
                begin
                    exp_bytes[0] = SLIP_ESC;
                    exp_bytes[1] = (q_job.b0 == SLIP_END) ? SLIP_TEND : SLIP_TESC;
                    exp_cnt      = RUN_W'(2);
                end
                else
                begin
                    exp_bytes[0] = q_job.b0;
                    exp_cnt      = RUN_W'(1);
                end
            end
            JOB_END:
            begin
                // crc low, crc high, then frame end
                if (q_job.b0 == SLIP_END || q_job.b0 == SLIP_ESC)
                begin
                    exp_bytes[0] = SLIP_ESC;
                    exp_bytes[1] = (q_job.b0 == SLIP_END) ? SLIP_TEND : SLIP_TESC;
                    exp_cnt      = RUN_W'(2);
                end
                else
                begin
                    exp_bytes[0] = q_job.b0;
                    exp_cnt      = RUN_W'(1);
                end
                if (q_job.b1 == SLIP_END || q_job.b1 == SLIP_ESC)
                begin
                    exp_bytes[exp_cnt]          = SLIP_ESC;
                    exp_bytes[exp_cnt + RUN_ONE] = (q_job.b1 == SLIP_END) ? SLIP_TEND
                                                                          : SLIP_TESC;
                    exp_cnt = exp_cnt + RUN_W'(2);
                end
                else
                begin
                    exp_bytes[exp_cnt] = q_job.b1;
                    exp_cnt            = exp_cnt + RUN_ONE;
                end
                exp_bytes[exp_cnt] = SLIP_END;
                exp_cnt            = exp_cnt + RUN_ONE;
            end
            default:
            begin
                exp_cnt = RUN_ONE;
            end
        endcase
    end

    // run sequencing and output register
    always_comb
    begin
        run_bytes_next      = run_bytes_reg;
        run_cnt_next        = run_cnt_reg;
        run_idx_next        = run_idx_reg;
        run_end_next        = run_end_reg;
        run_dest_next       = run_dest_reg;
        run_active_next     = run_active_reg;
        out_valid_next      = out_valid_reg;
        out_byte_next       = out_byte_reg;
        out_dest_next       = out_dest_reg;
        out_run_last_next   = out_run_last_reg;
        out_frame_last_next = out_frame_last_reg;

        if (out_valid_reg && m_tready)
        begin
            out_valid_next = 1'b0;
        end

        if (emit)
        begin
            out_valid_next      = 1'b1;
            out_byte_next       = run_bytes_reg[run_idx_reg];
            out_dest_next       = run_dest_reg;
            out_run_last_next   = last;
            out_frame_last_next = last && run_end_reg;
            run_idx_next        = run_idx_reg + RUN_ONE;
            if (last)
            begin
                run_active_next = 1'b0;
            end
        end

        if (q_pop)
        begin
            run_bytes_next  = exp_bytes;
            run_cnt_next    = exp_cnt;
            run_idx_next    = '0;
            run_end_next    = (q_job.kind == JOB_END);
            run_dest_next   = q_job.dest;
            run_active_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_active_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            run_active_reg <= run_active_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        run_bytes_reg      <= run_bytes_next;
        run_cnt_reg        <= run_cnt_next;
        run_idx_reg        <= run_idx_next;
        run_end_reg        <= run_end_next;
        run_dest_reg       <= run_dest_next;
        out_byte_reg       <= out_byte_next;
        out_dest_reg       <= out_dest_next;
        out_run_last_reg   <= out_run_last_next;
        out_frame_last_reg <= out_frame_last_next;
    end

endmodule

`default_nettype wire

FILE: src/slip_crc16_frame_builder.sv
// slip_crc16_frame_builder: slip frame builder with reflected crc-16 trailer
// path: an accepted beat is written to the job queue, loaded into the run registers, then sent from the output register
// throughput: payload and end beats accepted every cycle while the job queue has room;
//   a start beat holds the input while the crc folds the source and control bytes, one header byte per cycle;
//   the output sends one frame byte per cycle while m_tready is high, so escaped bytes set the sustained rate
// reset: asynchronous active low; crc to 0xffff, no frame open, queue and output empty
`default_nettype none

module slip_crc16_frame_builder #(
    parameter int unsigned QUEUE_DEPTH = 4
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,   // dest_address, source_address, control_field, payload_byte
    input  wire logic [1:0]  s_tuser,   // operation
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [15:0]      m_tdata,   // frame_byte, frame_dest
    output logic [0:0]       m_tuser,   // run_last
    output logic             m_tlast    // frame_last
);
    import sfb_pkg::*;

    logic q_push, q_full, q_pop, q_empty;
    job_t push_job, pop_job;

    // front: classify beats, crc, frame state
    sfb_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_job    (push_job)
    );

    // job queue
    sfb_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_job (push_job),
        .full     (q_full),
        .pop      (q_pop),
        .pop_job  (pop_job),
        .empty    (q_empty)
    );

    // back: escape and send bytes
    sfb_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_empty  (q_empty),
        .q_job    (pop_job),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

`default_nettype wire
